FILE: rtl/core/dbw_pkg.sv
package dbw_pkg;

    // Field widths
    localparam int PIX_W   = 16;
    localparam int DEPTH_W = 16;
    localparam int TAG_W   = 16;
    localparam int FOC_W   = 24;
    localparam int ROT_W   = 18;
    localparam int TRN_W   = 20;
    localparam int WORLD_W = 32;
    localparam int CFG_W   = 60;
    localparam int ROW_W   = 3 * ROT_W;

    // Internal widths
    localparam int OFF_W  = PIX_W + 1;            // signed pixel offset, Q.4
    localparam int OD_W   = OFF_W + DEPTH_W;      // offset * depth, Q.12
    localparam int RAW_W  = OD_W + FOC_W + 1;     // times inverse focal, Q.36
    localparam int CAM_W  = 45;                   // camera point, Q.24
    localparam int PROD_W = ROT_W + CAM_W;        // rotation product, Q.40
    localparam int ACC_W  = 64;                   // row sum, Q.40
    localparam int SUM_W  = ACC_W - 24;           // rounded row sum, Q.16

    typedef logic signed [CAM_W-1:0]  cam_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_PRINCIPAL_X = 3'd0,
        CFG_PRINCIPAL_Y = 3'd1,
        CFG_INV_FOCAL_X = 3'd2,
        CFG_INV_FOCAL_Y = 3'd3,
        CFG_ROT_ROW0    = 3'd4,
        CFG_ROT_ROW1    = 3'd5,
        CFG_ROT_ROW2    = 3'd6,
        CFG_TRANSLATION = 3'd7
    } cfg_index_t;

    // Stage enables for one rotation row
    typedef struct packed {
        logic prod_en;
        logic sum_en;
    } row_ctl_t;

    // Clamp a rounded row sum to the signed 32-bit range
    function automatic logic signed [WORLD_W-1:0] sat_world(input sum_t v);
        logic signed [WORLD_W-1:0] r;
        if (v > sum_t'(64'sh0000_0000_7FFF_FFFF))
            r = 32'sh7FFF_FFFF;
        else if (v < sum_t'(-64'sh0000_0000_8000_0000))
            r = 32'sh8000_0000;
        else
            r = v[WORLD_W-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/dbw_if.sv
interface dbw_in_if;
    import dbw_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [PIX_W-1:0]          pixel_x;
    logic [PIX_W-1:0]          pixel_y;
    logic signed [DEPTH_W-1:0] depth;
    logic [TAG_W-1:0]          point_tag;

    modport source (output valid, pixel_x, pixel_y, depth, point_tag, input ready);
    modport sink   (input valid, pixel_x, pixel_y, depth, point_tag, output ready);
endinterface

interface dbw_out_if;
    import dbw_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [WORLD_W-1:0] world_x;
    logic signed [WORLD_W-1:0] world_y;
    logic signed [WORLD_W-1:0] world_z;
    logic                      valid_res;
    logic [TAG_W-1:0]          result_tag;

    modport source (output valid, world_x, world_y, world_z, valid_res, result_tag,
                    input ready);
    modport sink   (input valid, world_x, world_y, world_z, valid_res, result_tag,
                    output ready);
endinterface

FILE: rtl/core/depth_backproject_to_world.sv
// Back-projects one keypoint (pixel, depth) through a pinhole camera and moves it
// into the world frame with R * p + t. The block takes one request per clock while
// keypoint.ready is high and passes it through seven register stages: offset,
// offset*depth, times inverse focal, rounding, rotation products, row sums,
// saturation. Every stage has its own valid bit and stalls only when the stage
// after it is full, so empty slots in the pipe are squeezed out under back-pressure.
// A depth of zero or below gives a zero world point with valid_res low; the tag
// always passes through. Configuration is written through cfg_we/cfg_index/cfg_data
// and should only change while no request is in flight.
module depth_backproject_to_world (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [dbw_pkg::CFG_W-1:0] cfg_data,
    dbw_in_if.sink                    keypoint,
    dbw_out_if.source                 world
);
    import dbw_pkg::*;

    localparam int NS = 7;

    // Configuration registers
    logic [PIX_W-1:0] principal_x_reg, principal_y_reg;
    logic [FOC_W-1:0] inv_focal_x_reg, inv_focal_y_reg;
    logic [ROW_W-1:0] rot_row0_reg, rot_row1_reg, rot_row2_reg;
    logic [CFG_W-1:0] translation_reg;

    // Pipeline control
    logic [NS-1:0]    v_reg;
    logic [NS-1:0]    v_next;
    logic [NS-1:0]    en;
    logic [TAG_W-1:0] tag_reg [NS];
    logic [NS-1:0]    pos_reg;

    // Datapath registers
    logic signed [OFF_W-1:0]   offx_reg, offy_reg;
    logic signed [DEPTH_W-1:0] d1_reg, d2_reg, d3_reg;
    logic signed [OD_W-1:0]    odx_reg, ody_reg;
    logic signed [RAW_W-1:0]   rawx_reg, rawy_reg;
    logic signed [RAW_W-1:0]   rawx_rnd, rawy_rnd;
    cam_t                      camx_reg, camy_reg, camz_reg;
    sum_t                      sum0, sum1, sum2;
    row_ctl_t                  row_ctl;
    logic signed [WORLD_W-1:0] wx_reg, wy_reg, wz_reg;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            principal_x_reg <= '0;
            principal_y_reg <= '0;
            inv_focal_x_reg <= '0;
            inv_focal_y_reg <= '0;
            rot_row0_reg    <= '0;
            rot_row1_reg    <= '0;
            rot_row2_reg    <= '0;
            translation_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PRINCIPAL_X: principal_x_reg <= cfg_data[PIX_W-1:0];
                CFG_PRINCIPAL_Y: principal_y_reg <= cfg_data[PIX_W-1:0];
                CFG_INV_FOCAL_X: inv_focal_x_reg <= cfg_data[FOC_W-1:0];
                CFG_INV_FOCAL_Y: inv_focal_y_reg <= cfg_data[FOC_W-1:0];
                CFG_ROT_ROW0:    rot_row0_reg    <= cfg_data[ROW_W-1:0];
                CFG_ROT_ROW1:    rot_row1_reg    <= cfg_data[ROW_W-1:0];
                CFG_ROT_ROW2:    rot_row2_reg    <= cfg_data[ROW_W-1:0];
                CFG_TRANSLATION: translation_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Advance a stage when it is empty or the stage after it advances
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || world.ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next = v_reg;
        if (en[0])
            v_next[0] = keypoint.valid;
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
                v_next[k] = v_reg[k-1];
        end
    end

    assign keypoint.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    // Carry tag and depth-positive flag along the pipe
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            tag_reg[0] <= keypoint.point_tag;
            pos_reg[0] <= (keypoint.depth > 16'sd0);
        end
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
            begin
                tag_reg[k] <= tag_reg[k-1];
                pos_reg[k] <= pos_reg[k-1];
            end
        end
    end

    // Round the Q.36 products half up to Q.24
    assign rawx_rnd = rawx_reg + RAW_W'(2048);
    assign rawy_rnd = rawy_reg + RAW_W'(2048);

    // Back-projection stages
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            offx_reg <= $signed({1'b0, keypoint.pixel_x}) - $signed({1'b0, principal_x_reg});
            offy_reg <= $signed({1'b0, keypoint.pixel_y}) - $signed({1'b0, principal_y_reg});
            d1_reg   <= keypoint.depth;
        end
        if (en[1])
        begin
            odx_reg <= offx_reg * d1_reg;
            ody_reg <= offy_reg * d1_reg;
            d2_reg  <= d1_reg;
        end
        if (en[2])
        begin
            rawx_reg <= odx_reg * $signed({1'b0, inv_focal_x_reg});
            rawy_reg <= ody_reg * $signed({1'b0, inv_focal_y_reg});
            d3_reg   <= d2_reg;
        end
        if (en[3])
        begin
            camx_reg <= rawx_rnd[CAM_W+11:12];
            camy_reg <= rawy_rnd[CAM_W+11:12];
            camz_reg <= {{(CAM_W-DEPTH_W-16){d3_reg[DEPTH_W-1]}}, d3_reg, 16'd0};
        end
    end

    // Rotation and translation, one unit per output row
    assign row_ctl.prod_en = en[4];
    assign row_ctl.sum_en  = en[5];

    dbw_row u_row0 (
        .clk     (clk),
        .ctl     (row_ctl),
        .cam0    (camx_reg),
        .cam1    (camy_reg),
        .cam2    (camz_reg),
        .rot_row (rot_row0_reg),
        .trans   (translation_reg[TRN_W-1:0]),
        .sum     (sum0)
    );

    dbw_row u_row1 (
        .clk     (clk),
        .ctl     (row_ctl),
        .cam0    (camx_reg),
        .cam1    (camy_reg),
        .cam2    (camz_reg),
        .rot_row (rot_row1_reg),
        .trans   (translation_reg[2*TRN_W-1:TRN_W]),
        .sum     (sum1)
    );

    dbw_row u_row2 (
        .clk     (clk),
        .ctl     (row_ctl),
        .cam0    (camx_reg),
        .cam1    (camy_reg),
        .cam2    (camz_reg),
        .rot_row (rot_row2_reg),
        .trans   (translation_reg[3*TRN_W-1:2*TRN_W]),
        .sum     (sum2)
    );

    // Saturate, drop to zero for a missing depth
    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            wx_reg <= pos_reg[5] ? sat_world(sum0) : '0;
            wy_reg <= pos_reg[5] ? sat_world(sum1) : '0;
            wz_reg <= pos_reg[5] ? sat_world(sum2) : '0;
        end
    end

    assign world.valid      = v_reg[NS-1];
    assign world.world_x    = wx_reg;
    assign world.world_y    = wy_reg;
    assign world.world_z    = wz_reg;
    assign world.valid_res  = pos_reg[NS-1];
    assign world.result_tag = tag_reg[NS-1];

`ifndef SYNTHESIS
    // A result without depth carries the zero vector
    assert property (@(posedge clk) disable iff (!rst_n)
        world.valid && !world.valid_res |->
            world.world_x == 0 && world.world_y == 0 && world.world_z == 0)
        else $error("missing-depth result is not zero");

    // An accepted request lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        keypoint.valid && keypoint.ready |=> v_reg[0])
        else $error("accepted request not captured");

    // A full, stalled pipe takes no new request
    assert property (@(posedge clk) disable iff (!rst_n)
        (&v_reg) && !world.ready |-> !keypoint.ready)
        else $error("request taken into a full stalled pipe");

    // A stalled last stage keeps its tag
    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NS-1] && !world.ready |=> $stable(tag_reg[NS-1]))
        else $error("stalled result tag changed");
`endif

endmodule

FILE: rtl/core/dbw_row.sv
module dbw_row (
    input  logic                      clk,
    input  dbw_pkg::row_ctl_t         ctl,
    input  dbw_pkg::cam_t             cam0,
    input  dbw_pkg::cam_t             cam1,
    input  dbw_pkg::cam_t             cam2,
    input  logic [dbw_pkg::ROW_W-1:0] rot_row,
    input  logic [dbw_pkg::TRN_W-1:0] trans,
    output dbw_pkg::sum_t             sum
);
    import dbw_pkg::*;

    prod_t p0_reg, p1_reg, p2_reg;
    prod_t p0_next, p1_next, p2_next;
    sum_t  sum_reg, sum_next;
    logic signed [ACC_W-1:0] acc;

    // Multiply each rotation entry by its camera coordinate
    always_comb
    begin
        p0_next = $signed(rot_row[ROT_W-1:0]) * cam0;
        p1_next = $signed(rot_row[2*ROT_W-1:ROT_W]) * cam1;
        p2_next = $signed(rot_row[3*ROT_W-1:2*ROT_W]) * cam2;
    end

    // Sum products and translation at Q.40, round half up to Q.16
    always_comb
    begin
        acc = ACC_W'(p0_reg) + ACC_W'(p1_reg) + ACC_W'(p2_reg)
            + {{(ACC_W-TRN_W-28){trans[TRN_W-1]}}, trans, 28'd0}
            + ACC_W'(64'sd8388608);
        sum_next = acc[ACC_W-1:24];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.prod_en)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
        if (ctl.sum_en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule
